>>> rtl/spfg_pkg.sv
// Shared types and constants for the servo pulse frame generator.
package spfg_pkg;

   localparam int CHAN_W        = 3;
   localparam int VALUE_W       = 8;
   localparam int PINS_W        = 6;
   localparam int SLOT_W        = 5;
   localparam int PULSE_W       = 10;
   localparam int UPTIME_W      = 32;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 6;
   localparam int NUM_SLOT_REGS = 6;

   // Pulse length is 2*value plus this base, in fine ticks.
   localparam logic [PULSE_W-1:0] PULSE_BASE = 10'd126;

   localparam logic [PINS_W-1:0] ENABLE_RESET = 6'h3F;
   // Default slot of channel i is 3*i.
   localparam int SLOT_STEP = 3;

   typedef enum logic [1:0] {
      REQ_MS_TICK   = 2'd0,
      REQ_FINE_TICK = 2'd1,
      REQ_WRITE     = 2'd2,
      REQ_READ      = 2'd3
   } req_kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ENABLE_MASK = 3'd0,
      CSR_SLOT_CH0    = 3'd1,
      CSR_SLOT_CH1    = 3'd2,
      CSR_SLOT_CH2    = 3'd3,
      CSR_SLOT_CH3    = 3'd4,
      CSR_SLOT_CH4    = 3'd5,
      CSR_SLOT_CH5    = 3'd6,
      CSR_UNUSED      = 3'd7
   } csr_index_type;

   typedef logic [SLOT_W-1:0] slot_type;

   typedef struct packed {
      logic              hit;
      logic [CHAN_W-1:0] chan;
   } slot_hit_type;

endpackage

>>> rtl/servo_pulse_frame_generator.sv
// Top level of the six-channel hobby-servo pulse frame generator.
//
// Each request word is one event: a millisecond tick, a fine pulse-clock tick, a servo
// value write or a servo value read, and each one yields exactly one response word that
// carries the pin levels, the read data (zero unless an enabled channel is read) and the
// millisecond uptime as they stand after the event. A millisecond tick checks the current
// slot of the frame; the lowest enabled channel assigned to that slot raises its pin and
// (re)loads the pulse count with 2*value+126 fine ticks, then the slot counter advances
// (wrapping at FRAME_SLOTS) and uptime increments. Fine ticks count the pulse down, and
// when it runs out all pins drop together. The block is a two-register pipeline: a request
// register feeding a response register through one pass of short logic, so a new word is
// accepted every clock cycle while rsp_ready stays high, and each response is presented at
// the response port once its request has moved on into the response register. While a
// finished response waits for rsp_ready, the request register can still take one more
// word; after that req_ready stays low until the response is taken, and in that state
// req_ready follows rsp_ready combinationally. Configuration writes are taken on any cycle
// (csr_ready is always high) and should be issued only while no request is in flight.
module servo_pulse_frame_generator #(
   parameter int NUM_CHANNELS = 6,
   parameter int FRAME_SLOTS  = 20
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_type,
   input  logic [spfg_pkg::CHAN_W-1:0]       req_channel,
   input  logic [spfg_pkg::VALUE_W-1:0]      req_value,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [spfg_pkg::PINS_W-1:0]       rsp_servo_pins,
   output logic [spfg_pkg::VALUE_W-1:0]      rsp_read_value,
   output logic [spfg_pkg::UPTIME_W-1:0]     rsp_uptime_ms,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [spfg_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [spfg_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import spfg_pkg::*;

   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   // Configuration registers.
   logic [PINS_W-1:0] enable_mask_ff;
   slot_type          slot_regs_ff [NUM_SLOT_REGS];

   // Request register.
   logic               s1_valid_ff;
   req_kind_type       s1_kind_ff;
   logic [CHAN_W-1:0]  s1_channel_ff;
   logic [VALUE_W-1:0] s1_value_ff;

   // Generator state.
   logic [VALUE_W-1:0]  servo_values_ff [NUM_CHANNELS];
   slot_type            slot_counter_ff, slot_counter_in;
   logic [PULSE_W-1:0]  pulse_remaining_ff, pulse_remaining_in;
   logic                pulse_running_ff, pulse_running_in;
   logic [PINS_W-1:0]   pin_levels_ff, pin_levels_in;
   logic [UPTIME_W-1:0] uptime_ff, uptime_in;

   // Response register.
   logic                out_valid_ff;
   logic [VALUE_W-1:0]  out_read_ff, out_read_in;

   logic               advance;
   slot_hit_type       slot_hit;
   logic [IDX_W-1:0]   val_addr;
   logic [VALUE_W-1:0] val_rdata;
   logic               ch_in_range;
   logic               ch_enabled;
   logic [SLOT_W:0]    slot_next;
   logic [PULSE_W-1:0] pulse_dec;

   // A word moves from the request register to the response register when the latter is
   // empty or being emptied in the same cycle.
   assign advance   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign csr_ready = 1'b1;

   assign rsp_valid      = out_valid_ff;
   assign rsp_servo_pins = pin_levels_ff;
   assign rsp_read_value = out_read_ff;
   assign rsp_uptime_ms  = uptime_ff;

   spfg_slot_match #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_slot_match (
      .enable_mask (enable_mask_ff),
      .slot_regs   (slot_regs_ff),
      .slot_count  (slot_counter_ff),
      .slot_hit    (slot_hit)
   );

   // One read address into the value store: the slot winner on a millisecond tick,
   // the addressed channel otherwise.
   assign val_addr  = (s1_kind_ff == REQ_MS_TICK) ? slot_hit.chan[IDX_W-1:0]
                                                  : s1_channel_ff[IDX_W-1:0];
   assign val_rdata = servo_values_ff[val_addr];

   assign ch_in_range = (32'(s1_channel_ff) < NUM_CHANNELS);
   assign ch_enabled  = ch_in_range && (32'(s1_channel_ff) < NUM_SLOT_REGS)
                        && enable_mask_ff[s1_channel_ff];

   assign slot_next = {1'b0, slot_counter_ff} + (SLOT_W+1)'(1);
   assign pulse_dec = (pulse_remaining_ff != '0) ? (pulse_remaining_ff - PULSE_W'(1)) : '0;

   always_comb begin
      slot_counter_in    = slot_counter_ff;
      pulse_remaining_in = pulse_remaining_ff;
      pulse_running_in   = pulse_running_ff;
      pin_levels_in      = pin_levels_ff;
      uptime_in          = uptime_ff;
      out_read_in        = '0;
      case (s1_kind_ff)
         REQ_MS_TICK: begin
            if (slot_hit.hit) begin
               pin_levels_in      = pin_levels_ff | (PINS_W'(1) << slot_hit.chan);
               pulse_remaining_in = {1'b0, val_rdata, 1'b0} + PULSE_BASE;
               pulse_running_in   = 1'b1;
            end
            slot_counter_in = (32'(slot_next) >= FRAME_SLOTS) ? '0 : slot_next[SLOT_W-1:0];
            uptime_in       = uptime_ff + UPTIME_W'(1);
         end
         REQ_FINE_TICK: begin
            if (pulse_running_ff) begin
               pulse_remaining_in = pulse_dec;
               if (pulse_dec == '0) begin
                  pin_levels_in    = '0;
                  pulse_running_in = 1'b0;
               end
            end
         end
         REQ_READ: begin
            if (ch_enabled) begin
               out_read_in = val_rdata;
            end
         end
         default: begin
            // Writes touch only the value store.
         end
      endcase
   end

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         s1_kind_ff    <= req_kind_type'(req_type);
         s1_channel_ff <= req_channel;
         s1_value_ff   <= req_value;
      end
   end

   // Generator state and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_counter_ff    <= '0;
         pulse_remaining_ff <= '0;
         pulse_running_ff   <= 1'b0;
         pin_levels_ff      <= '0;
         uptime_ff          <= '0;
         out_valid_ff       <= 1'b0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            servo_values_ff[i] <= '0;
         end
      end else begin
         if (advance) begin
            slot_counter_ff    <= slot_counter_in;
            pulse_remaining_ff <= pulse_remaining_in;
            pulse_running_ff   <= pulse_running_in;
            pin_levels_ff      <= pin_levels_in;
            uptime_ff          <= uptime_in;
            out_valid_ff       <= 1'b1;
            if ((s1_kind_ff == REQ_WRITE) && ch_in_range) begin
               servo_values_ff[s1_channel_ff[IDX_W-1:0]] <= s1_value_ff;
            end
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_read_ff <= out_read_in;
      end
   end

   // Configuration registers. Indexes past the last slot register are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_mask_ff <= ENABLE_RESET;
         for (int i = 0; i < NUM_SLOT_REGS; i++) begin
            slot_regs_ff[i] <= SLOT_W'(SLOT_STEP * i);
         end
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_ENABLE_MASK: begin
               enable_mask_ff <= csr_wdata;
            end
            CSR_SLOT_CH0, CSR_SLOT_CH1, CSR_SLOT_CH2,
            CSR_SLOT_CH3, CSR_SLOT_CH4, CSR_SLOT_CH5: begin
               slot_regs_ff[csr_index - CSR_SLOT_CH0] <= csr_wdata[SLOT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Pins are only ever high while a pulse count is running.
   assert property (@(posedge clock) disable iff (reset)
      (pin_levels_ff != '0) |-> pulse_running_ff)
      else $error("servo pins high with no pulse running");

   // A running pulse always has count left.
   assert property (@(posedge clock) disable iff (reset)
      pulse_running_ff |-> (pulse_remaining_ff != '0))
      else $error("pulse running with zero count");

   // The slot counter stays inside the frame.
   assert property (@(posedge clock) disable iff (reset)
      (32'(slot_counter_ff) < FRAME_SLOTS))
      else $error("slot counter outside the frame");

   // Each processed millisecond tick adds exactly one to uptime.
   assert property (@(posedge clock) disable iff (reset)
      (advance && (s1_kind_ff == REQ_MS_TICK)) |=>
         (uptime_ff == ($past(uptime_ff) + UPTIME_W'(1))))
      else $error("uptime did not step on a millisecond tick");

endmodule

>>> rtl/spfg_slot_match.sv
// Finds the lowest enabled channel whose frame slot equals the current slot.
module spfg_slot_match #(
   parameter int NUM_CHANNELS = 6
) (
   input  logic [spfg_pkg::PINS_W-1:0] enable_mask,
   input  spfg_pkg::slot_type          slot_regs [spfg_pkg::NUM_SLOT_REGS],
   input  spfg_pkg::slot_type          slot_count,
   output spfg_pkg::slot_hit_type      slot_hit
);
   import spfg_pkg::*;

   localparam int ACTIVE_CH = (NUM_CHANNELS < NUM_SLOT_REGS) ? NUM_CHANNELS : NUM_SLOT_REGS;

   // Scan from the top down so the lowest matching channel is left standing.
   always_comb begin
      slot_hit = '0;
      for (int i = ACTIVE_CH - 1; i >= 0; i--) begin
         if (enable_mask[i] && (slot_regs[i] == slot_count)) begin
            slot_hit.hit  = 1'b1;
            slot_hit.chan = CHAN_W'(i);
         end
      end
   end

endmodule
